[rtl/ast_pkg.sv]
// types and character constants for the argument string tokenizer
`timescale 1ns / 1ps

package ast_pkg;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_LO     = 8'h6F;
  localparam logic [7:0] CH_UL     = 8'h4C;
  localparam logic [7:0] CH_UI     = 8'h49;

  localparam int unsigned MAX_RES = 3;

  typedef enum logic [3:0] {
    PH_START  = 4'b0001,
    PH_DASH   = 4'b0010,
    PH_LETTER = 4'b0100,
    PH_PASS   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       token_end;
    logic       string_done;
    logic       run_last;
  } res_t;

  function automatic res_t mk_res(input logic [7:0] b, input logic bv,
                                  input logic te, input logic dn);
    res_t r;
    r.out_byte    = b;
    r.byte_valid  = bv;
    r.token_end   = te;
    r.string_done = dn;
    r.run_last    = 1'b0;
    return r;
  endfunction

endpackage

[rtl/arg_string_tokenizer.sv]
// argument string tokenizer: splits a byte stream into tokens and flag prefixes
`timescale 1ns / 1ps
//
// Input channel (in_valid / in_stall) carries one byte of the argument string per
// transaction, or a terminator when is_end is high. Output channel (out_valid /
// out_stall) carries one token byte or bare end marker per transaction; token_end
// closes a token, string_done closes the last token of the string, run_last marks
// the last result caused by one input transaction.
// An input accepted into the input register moves on into the result buffer, whose
// head drives out_valid. The input register takes a new byte in the same cycle that
// its held byte moves on, which needs the buffer empty or its last result leaving.
// Throughput: one byte per cycle for bytes giving zero or one result, while the
// receiver does not stall; a byte that releases held flag bytes gives two or three
// results, drained from the three-entry result buffer one per cycle while the receiver
// does not stall, so the input register holds until the last of them is leaving.
// Reset clears quoting, escape and prefix state, the input register and the buffer.
// When the receiver stalls, the head result holds; the buffer and then the input
// register fill and in_stall rises.
// A terminator returns all tokenizer state to its reset values.

module arg_string_tokenizer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       is_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       token_end,
  output logic       string_done,
  output logic       run_last
);
  import ast_pkg::*;

  // input register
  logic       item_valid;
  logic [7:0] item_byte;
  logic       item_end;

  // tokenizer state
  logic       in_quotes, in_quotes_next;
  logic       escape_pending, escape_pending_next;
  phase_t     phase, phase_next;
  logic [7:0] held_letter, held_letter_next;

  // result buffer
  res_t       rbuf [MAX_RES];
  logic [1:0] count;

  res_t       res [MAX_RES];
  logic [1:0] n;
  logic       do_content, do_close, close_done;
  logic       pop, move, in_accept;

  assign pop       = (count != 2'd0) && !out_stall;
  assign move      = item_valid && ((count == 2'd0) || ((count == 2'd1) && pop));
  assign in_stall  = item_valid && !move;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    res[0]              = mk_res(8'h00, 1'b0, 1'b0, 1'b0);
    res[1]              = mk_res(8'h00, 1'b0, 1'b0, 1'b0);
    res[2]              = mk_res(8'h00, 1'b0, 1'b0, 1'b0);
    n                   = 2'd0;
    in_quotes_next      = in_quotes;
    escape_pending_next = escape_pending;
    phase_next          = phase;
    held_letter_next    = held_letter;
    do_content          = 1'b0;
    do_close            = 1'b0;
    close_done          = 1'b0;

    priority if (item_end) begin
      do_close            = 1'b1;
      close_done          = 1'b1;
      in_quotes_next      = 1'b0;
      escape_pending_next = 1'b0;
    end else if (escape_pending) begin
      escape_pending_next = 1'b0;
      do_content          = 1'b1;
    end else if (item_byte == CH_BSLASH) begin
      escape_pending_next = 1'b1;
    end else if (item_byte == CH_QUOTE) begin
      in_quotes_next = ~in_quotes;
    end else if ((item_byte == CH_SPACE) && !in_quotes) begin
      do_close = 1'b1;
    end else begin
      do_content = 1'b1;
    end

    if (do_content) begin
      unique case (phase)
        PH_START: begin
          if (item_byte == CH_DASH) begin
            phase_next = PH_DASH;
          end else begin
            res[0]     = mk_res(item_byte, 1'b1, 1'b0, 1'b0);
            n          = 2'd1;
            phase_next = PH_PASS;
          end
        end
        PH_DASH: begin
          if ((item_byte == CH_LO) || (item_byte == CH_UL) || (item_byte == CH_UI)) begin
            held_letter_next = item_byte;
            phase_next       = PH_LETTER;
          end else begin
            res[0]     = mk_res(CH_DASH, 1'b1, 1'b0, 1'b0);
            res[1]     = mk_res(item_byte, 1'b1, 1'b0, 1'b0);
            n          = 2'd2;
            phase_next = PH_PASS;
          end
        end
        PH_LETTER: begin
          res[0]           = mk_res(CH_DASH, 1'b1, 1'b0, 1'b0);
          res[1]           = mk_res(held_letter, 1'b1, 1'b1, 1'b0);
          res[2]           = mk_res(item_byte, 1'b1, 1'b0, 1'b0);
          n                = 2'd3;
          held_letter_next = 8'h00;
          phase_next       = PH_PASS;
        end
        PH_PASS: begin
          res[0] = mk_res(item_byte, 1'b1, 1'b0, 1'b0);
          n      = 2'd1;
        end
        default: begin
          phase_next = PH_START;
        end
      endcase
    end else if (do_close) begin
      priority if (phase == PH_DASH) begin
        res[0] = mk_res(CH_DASH, 1'b1, 1'b1, close_done);
        n      = 2'd1;
      end else if (phase == PH_LETTER) begin
        res[0] = mk_res(CH_DASH, 1'b1, 1'b0, 1'b0);
        res[1] = mk_res(held_letter, 1'b1, 1'b1, close_done);
        n      = 2'd2;
      end else begin
        res[0] = mk_res(8'h00, 1'b0, 1'b1, close_done);
        n      = 2'd1;
      end
      phase_next       = PH_START;
      held_letter_next = 8'h00;
    end

    unique case (n)
      2'd1:    res[0].run_last = 1'b1;
      2'd2:    res[1].run_last = 1'b1;
      2'd3:    res[2].run_last = 1'b1;
      default: ;
    endcase
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_accept) begin
      item_valid <= 1'b1;
    end else if (move) begin
      item_valid <= 1'b0;
    end
    if (in_accept) begin
      item_byte <= in_byte;
      item_end  <= is_end;
    end
  end

  // tokenizer state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_quotes      <= 1'b0;
      escape_pending <= 1'b0;
      phase          <= PH_START;
      held_letter    <= 8'h00;
    end else if (move) begin
      in_quotes      <= in_quotes_next;
      escape_pending <= escape_pending_next;
      phase          <= phase_next;
      held_letter    <= held_letter_next;
    end
  end

  // result buffer, head at entry 0
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (move) begin
      count <= n;
    end else if (pop) begin
      count <= count - 2'd1;
    end
    if (move) begin
      rbuf[0] <= res[0];
      rbuf[1] <= res[1];
      rbuf[2] <= res[2];
    end else if (pop) begin
      rbuf[0] <= rbuf[1];
      rbuf[1] <= rbuf[2];
    end
  end

  assign out_valid   = (count != 2'd0);
  assign out_byte    = rbuf[0].out_byte;
  assign byte_valid  = rbuf[0].byte_valid;
  assign token_end   = rbuf[0].token_end;
  assign string_done = rbuf[0].string_done;
  assign run_last    = rbuf[0].run_last;

endmodule

[rtl/ast_checker.sv]
// port-level checks for the argument string tokenizer, with bind
`timescale 1ns / 1ps

module ast_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       byte_valid,
  input logic       token_end,
  input logic       string_done,
  input logic       run_last
);

  // stalled output transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(byte_valid)
      && $stable(token_end) && $stable(string_done) && $stable(run_last))
    else $error("stalled output transaction changed");

  // string close is always a token close and the last result of its input
  a_done_closes: assert property (@(posedge clk) disable iff (rst)
    out_valid && string_done |-> token_end && run_last)
    else $error("string_done without token_end and run_last");

  // bare end marker is a lone zero result closing a token
  a_bare_marker: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> token_end && run_last && (out_byte == 8'h00))
    else $error("malformed bare end marker");

  // nothing leaves straight after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind arg_string_tokenizer ast_checker u_ast_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_byte    (out_byte),
  .byte_valid  (byte_valid),
  .token_end   (token_end),
  .string_done (string_done),
  .run_last    (run_last)
);

[verif/arg_string_tokenizer_check.sv]
// checker for the argument string tokenizer: predicts token results and compares them
`timescale 1ns / 1ps

module arg_string_tokenizer_check (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       is_end,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte,
  input  logic       byte_valid,
  input  logic       token_end,
  input  logic       string_done,
  input  logic       run_last,
  output int         errors,
  output int         pending,
  output int         checked
);
  import ast_pkg::*;

  phase_t     phase;
  logic       quoted;
  logic       escaped;
  logic [7:0] held;
  res_t       token_results[$];
  res_t       burst[$];

  function automatic void emit(input logic [7:0] b, input logic bv, input logic te,
                               input logic dn);
    res_t r;
    r.out_byte    = b;
    r.byte_valid  = bv;
    r.token_end   = te;
    r.string_done = dn;
    r.run_last    = 1'b0;
    burst.push_back(r);
  endfunction

  function automatic void take_content(input logic [7:0] b);
    case (phase)
      PH_START: begin
        if (b == CH_DASH) begin
          phase = PH_DASH;
        end else begin
          emit(b, 1'b1, 1'b0, 1'b0);
          phase = PH_PASS;
        end
      end
      PH_DASH: begin
        if (b == CH_LO || b == CH_UL || b == CH_UI) begin
          held  = b;
          phase = PH_LETTER;
        end else begin
          emit(CH_DASH, 1'b1, 1'b0, 1'b0);
          emit(b, 1'b1, 1'b0, 1'b0);
          phase = PH_PASS;
        end
      end
      PH_LETTER: begin
        // flag splits off as its own token
        emit(CH_DASH, 1'b1, 1'b0, 1'b0);
        emit(held, 1'b1, 1'b1, 1'b0);
        emit(b, 1'b1, 1'b0, 1'b0);
        held  = 8'h00;
        phase = PH_PASS;
      end
      default: begin
        emit(b, 1'b1, 1'b0, 1'b0);
      end
    endcase
  endfunction

  function automatic void close_token(input logic dn);
    if (phase == PH_DASH) begin
      emit(CH_DASH, 1'b1, 1'b1, dn);
    end else if (phase == PH_LETTER) begin
      emit(CH_DASH, 1'b1, 1'b0, 1'b0);
      emit(held, 1'b1, 1'b1, dn);
    end else begin
      emit(8'h00, 1'b0, 1'b1, dn);
    end
    phase = PH_START;
    held  = 8'h00;
  endfunction

  function automatic void tokenize(input logic [7:0] b, input logic e);
    burst.delete();
    if (e) begin
      close_token(1'b1);
      quoted  = 1'b0;
      escaped = 1'b0;
    end else if (escaped) begin
      escaped = 1'b0;
      take_content(b);
    end else if (b == CH_BSLASH) begin
      escaped = 1'b1;
    end else if (b == CH_QUOTE) begin
      quoted = ~quoted;
    end else if (b == CH_SPACE && !quoted) begin
      close_token(1'b0);
    end else begin
      take_content(b);
    end
    if (burst.size() > 0) burst[burst.size() - 1].run_last = 1'b1;
    foreach (burst[i]) token_results.push_back(burst[i]);
  endfunction

  function automatic int check_field(input string name, input logic [7:0] want,
                                     input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : monitor
    res_t want;
    res_t got;
    if (rst) begin
      phase   = PH_START;
      quoted  = 1'b0;
      escaped = 1'b0;
      held    = 8'h00;
      errors  = 0;
      checked = 0;
      token_results.delete();
    end else begin
      if (in_valid && !in_stall) tokenize(in_byte, is_end);
      if (out_valid && !out_stall) begin
        got = '{out_byte, byte_valid, token_end, string_done, run_last};
        checked++;
        if (token_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0h", $time, got);
          errors++;
        end else begin
          want = token_results.pop_front();
          errors += check_field("out_byte", want.out_byte, got.out_byte);
          errors += check_field("byte_valid", want.byte_valid, got.byte_valid);
          errors += check_field("token_end", want.token_end, got.token_end);
          errors += check_field("string_done", want.string_done, got.string_done);
          errors += check_field("run_last", want.run_last, got.run_last);
        end
      end
    end
    pending = token_results.size();
  end

endmodule

[verif/arg_string_tokenizer_test.sv]
// testbench top for the argument string tokenizer: stimulus, watchdog and verdict
`timescale 1ns / 1ps

module arg_string_tokenizer_test;
  import ast_pkg::*;

  localparam int IDLE_LIMIT = 1000;
  localparam int ITEM_TARGET = 360;
  localparam logic [8:0] END_MARK = 9'h1A5;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       is_end = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       token_end;
  logic       string_done;
  logic       run_last;

  int   errors;
  int   pending;
  int   checked;
  int   items_sent = 0;
  int   strings_sent = 0;
  int   idle_cycles = 0;
  logic steady = 1'b0;

  always #1 clk = ~clk;

  arg_string_tokenizer uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte), .is_end(is_end),
    .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
    .byte_valid(byte_valid), .token_end(token_end), .string_done(string_done),
    .run_last(run_last)
  );

  arg_string_tokenizer_check check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte), .is_end(is_end),
    .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
    .byte_valid(byte_valid), .token_end(token_end), .string_done(string_done),
    .run_last(run_last),
    .errors(errors), .pending(pending), .checked(checked)
  );

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("arg_string_tokenizer_test: errors");
        $finish;
      end
    end
  end

  // result side back-pressure
  initial begin : receiver
    int n;
    @(posedge clk);
    forever begin
      n = steady ? 0 : $urandom_range(0, 3);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic e);
    int gap;
    in_valid <= 1'b1;
    in_byte  <= b;
    is_end   <= e;
    do @(posedge clk); while (in_stall !== 1'b0);
    items_sent++;
    if (e) strings_sent++;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_plain(input int n);
    repeat (n) send_byte(8'($urandom_range(8'h21, 8'h7E)), 1'b0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_char();
    logic [7:0] specials [7];
    specials = '{CH_SPACE, CH_QUOTE, CH_BSLASH, CH_DASH, CH_LO, CH_UL, CH_UI};
    if ($urandom_range(0, 3) == 0) return specials[$urandom_range(0, 6)];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_token();
    logic [7:0] flags [3];
    int n;
    flags = '{CH_LO, CH_UL, CH_UI};
    case ($urandom_range(0, 5))
      0: begin
        send_byte(CH_DASH, 1'b0);
        send_byte(flags[$urandom_range(0, 2)], 1'b0);
        send_plain($urandom_range(0, 3));
      end
      1: begin
        send_byte(CH_DASH, 1'b0);
        send_plain($urandom_range(1, 3));
      end
      2: send_plain($urandom_range(1, 4));
      3: begin
        send_byte(CH_QUOTE, 1'b0);
        n = $urandom_range(1, 4);
        repeat (n) send_byte($urandom_range(0, 2) == 0 ? CH_SPACE : pick_char(), 1'b0);
        if ($urandom_range(0, 3) != 0) send_byte(CH_QUOTE, 1'b0);
      end
      4: begin
        send_byte(CH_BSLASH, 1'b0);
        send_byte(pick_char(), 1'b0);
        send_plain($urandom_range(0, 2));
      end
      default: send_byte(CH_DASH, 1'b0);
    endcase
  endtask

  task automatic send_random_string();
    int ntok;
    int n;
    if ($urandom_range(0, 6) == 0) begin
      // noise string
      n = $urandom_range(1, 12);
      repeat (n) send_byte(pick_char(), 1'b0);
    end else begin
      ntok = $urandom_range(0, 4);
      for (int i = 0; i < ntok; i++) begin
        if (i > 0) begin
          send_byte(CH_SPACE, 1'b0);
          if ($urandom_range(0, 5) == 0) send_byte(CH_SPACE, 1'b0);
        end
        send_token();
      end
      if ($urandom_range(0, 7) == 0) send_byte(CH_BSLASH, 1'b0);
    end
    send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  initial begin : stimulus
    logic [8:0] directed[$];
    directed = '{
      END_MARK,
      {1'b0, CH_DASH}, {1'b0, CH_UI}, 9'h07A, {1'b0, CH_SPACE},
      {1'b0, CH_DASH}, 9'h071, {1'b0, CH_QUOTE}, {1'b0, CH_SPACE}, 9'h079,
      {1'b0, CH_QUOTE}, {1'b0, CH_SPACE}, {1'b0, CH_QUOTE}, 9'h000,
      {1'b0, CH_BSLASH}, {1'b0, CH_QUOTE}, {1'b0, CH_BSLASH}, {1'b0, CH_SPACE},
      9'h0FF, {1'b0, CH_BSLASH}, 9'h100,
      {1'b0, CH_DASH}, {1'b0, CH_UL}, {1'b0, CH_SPACE}, {1'b0, CH_DASH},
      {1'b0, CH_LO}, 9'h1FF,
      {1'b0, CH_DASH}, END_MARK
    };
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    foreach (directed[i]) send_byte(directed[i][7:0], directed[i][8]);
    wait_drained();
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 4) == 0) steady = ~steady;
      send_random_string();
      if ($urandom_range(0, 9) == 0) wait_drained();
    end
    steady = 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    $display("covered %0d input transactions in %0d strings, %0d results compared",
             items_sent, strings_sent, checked);
    $display("flag splits, held prefixes, quoting, escapes and random stalls on both sides");
    if (errors == 0 && pending == 0) begin
      $display("arg_string_tokenizer_test: clean");
    end else begin
      $display("arg_string_tokenizer_test: errors");
    end
    $finish;
  end

endmodule

[arg_string_tokenizer.f]
rtl/ast_pkg.sv
rtl/arg_string_tokenizer.sv
rtl/ast_checker.sv
verif/arg_string_tokenizer_check.sv
verif/arg_string_tokenizer_test.sv
